// ===== rtl/uv_sphere_vertex_generator_core_macros.svh =====
// Assertion helpers; both sample on clk_i and hold off while rst_ni is low.
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define UVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uvs check failed");

// next-cycle implication
`define UVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uvs check failed");

`endif

// ===== rtl/uvs_pkg.sv =====
`default_nettype none

package uvs_pkg;

  localparam int CFG_W = 9;

  typedef enum logic [0:0] {
    CFG_STEP_COUNT     = 1'b0,
    CFG_INWARD_NORMALS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0] lat_index;
    logic [8:0] lon_index;
  } in_word_t;

  typedef struct packed {
    logic [16:0]        vertex_number;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               index_clamped;
  } out_word_t;

  typedef struct packed {
    logic [16:0] vertex_number;
    logic        index_clamped;
  } vmeta_t;

  typedef struct packed {
    vmeta_t      base;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } tmeta_t;

  // pi/4 and 1.0 in Q30
  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // exact floor division of values below 2^31: (v * RCP) >> SH
  localparam int SH_42 = 37;
  localparam int SH_56 = 37;
  localparam int SH_20 = 36;
  localparam int SH_30 = 36;
  localparam int SH_6  = 34;
  localparam int SH_12 = 35;
  localparam logic [31:0] RCP_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [31:0] RCP_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [31:0] RCP_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [31:0] RCP_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [31:0] RCP_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
  localparam logic [31:0] RCP_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

endpackage

`default_nettype wire

// ===== rtl/uvs_stream_if.sv =====
`default_nettype none

interface uvs_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/uv_sphere_vertex_generator_core.sv =====
`default_nettype none
// channel | dir | word                        | handshake
// in_if   | in  | lat_index, lon_index        | valid/ready
// out_if  | out | vertex, xyz Q1.14, uv, flag | valid/ready
// cfg     | in  | cfg_we_i/cfg_idx_i/wdata    | write on cfg_we_i, no wait
//
// One word per cycle unless the output stalls; QW+11 register stages, 28 at ANGLE_BITS=16
// (QW = max(17, ANGLE_BITS+1) divider steps, plus init, 9 trig stages and output).
// Most of those stages are the radix-2 divider that forms the angle codes and uv.
// rst_ni (async, low) clears valid bits and loads step_count=16, inward off.
// A stall at the output freezes every stage at once; in_if.ready drops with it.

module uv_sphere_vertex_generator_core #(
  parameter int MAX_STEPS  = 256,
  parameter int ANGLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  uvs_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [uvs_pkg::CFG_W-1:0]   cfg_wdata_i,
  uvs_stream_if.sink                  in_if,
  uvs_stream_if.source                out_if
);
  import uvs_pkg::*;

  `include "uv_sphere_vertex_generator_core_macros.svh"

  localparam int NW    = $clog2(MAX_STEPS + 1);      // bits of n
  localparam int EW    = (NW > 9) ? NW : 9;          // compare width
  localparam int QW    = (ANGLE_BITS + 1 > 17) ? ANGLE_BITS + 1 : 17;
  localparam int DVW   = NW + 1;                     // divisor 2n
  localparam int DDW   = NW + QW + 1;                // dividend
  localparam int VW    = 2 * NW + 1;                 // vertex product
  localparam int RW    = ANGLE_BITS - 2;             // offset in quadrant
  localparam int PW    = RW + 30;
  localparam logic [RW:0] QUARTER = (RW + 1)'(1) << RW;
  localparam logic [RW-1:0] EIGHTH = RW'(1) << (ANGLE_BITS - 3);
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] ps;   // sine chain term
    logic [30:0] pc;   // cosine chain term
  } trig_t;

  typedef struct packed {
    logic signed [15:0] sn;
    logic signed [15:0] cs;
  } sc_t;

  function automatic logic [30:0] mul30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b);
    return p[60:30];
  endfunction

  function automatic logic [30:0] rdiv(input logic [30:0] v, input logic [31:0] m,
                                       input int s);
    logic [62:0] p;
    p = 63'(v) * 63'(m);
    return 31'(p >> s);
  endfunction

  function automatic logic signed [15:0] mulq14(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic flip);
    logic        neg;
    logic [14:0] ma;
    logic [14:0] mb;
    logic [29:0] p;
    logic [15:0] r;
    neg = a[15] ^ b[15] ^ flip;
    ma  = a[15] ? 15'(-a) : 15'(a);
    mb  = b[15] ? 15'(-b) : 15'(b);
    p   = 30'(ma) * 30'(mb) + 30'd8192;
    r   = 16'(p >> 14);
    return neg ? -r : r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [8:0] step_count_q;
  logic       inward_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= 9'd16;
      inward_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_COUNT:     step_count_q <= cfg_wdata_i[8:0];
        CFG_INWARD_NORMALS: inward_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------- global enable
  logic out_valid_q;
  logic en;
  assign en          = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  // ------------------------------------------------ stage 0: clamp, setup
  logic [EW-1:0]  n_ext;
  logic [EW-1:0]  lat_ext;
  logic [EW-1:0]  lon_ext;
  logic [NW-1:0]  n;
  logic [NW-1:0]  j;
  logic [NW-1:0]  i;
  logic           clamp;
  logic [VW-1:0]  vnum;
  logic [DDW-1:0] dvd [4];

  always_comb begin
    n_ext = EW'(step_count_q);
    if (n_ext == '0) n_ext = EW'(1);
    if (n_ext > EW'(MAX_STEPS)) n_ext = EW'(MAX_STEPS);
    n       = NW'(n_ext);
    lat_ext = EW'(in_if.data.lat_index);
    lon_ext = EW'(in_if.data.lon_index);
    clamp   = 1'b0;
    j       = NW'(lat_ext);
    i       = NW'(lon_ext);
    if (lat_ext > n_ext) begin
      j     = n;
      clamp = 1'b1;
    end
    if (lon_ext > n_ext) begin
      i     = n;
      clamp = 1'b1;
    end
    vnum   = VW'(j) * VW'({1'b0, n} + (NW + 1)'(1)) + VW'(i);
    // theta, phi codes; u, v as (x << 17 + 2*floor(n/2)) / 2n
    dvd[0] = (DDW'(j) << ANGLE_BITS) + DDW'(n);
    dvd[1] = (DDW'(i) << (ANGLE_BITS + 1)) + DDW'(n);
    dvd[2] = (DDW'(i) << 17) + DDW'({n[NW-1:1], 1'b0});
    dvd[3] = (DDW'(j) << 17) + DDW'({n[NW-1:1], 1'b0});
  end

  // ---------------------------------------------- radix-2 divider by 2n
  logic [QW:0]    dv_q;
  logic [DVW-1:0] rem_q  [QW+1][4];
  logic [QW-1:0]  quo_q  [QW+1][4];   // dividend low bits, then quotient
  logic [DVW-1:0] dsr_q  [QW+1];
  vmeta_t         dmeta_q[QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= {dv_q[QW-1:0], in_if.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsr_q[0]                 <= {n, 1'b0};
      dmeta_q[0].vertex_number <= 17'(vnum);
      dmeta_q[0].index_clamped <= clamp;
      for (int l = 0; l < 4; l++) begin
        rem_q[0][l] <= dvd[l][DDW-1:QW];
        quo_q[0][l] <= dvd[l][QW-1:0];
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [DVW:0] trial [4];
    logic         ge    [4];

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        trial[l] = {rem_q[k-1][l], quo_q[k-1][l][QW-1]};
        ge[l]    = trial[l] >= {1'b0, dsr_q[k-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dsr_q[k]   <= dsr_q[k-1];
        dmeta_q[k] <= dmeta_q[k-1];
        for (int l = 0; l < 4; l++) begin
          rem_q[k][l] <= ge[l] ? DVW'(trial[l] - {1'b0, dsr_q[k-1]}) : DVW'(trial[l]);
          quo_q[k][l] <= {quo_q[k-1][l][QW-2:0], ge[l]};
        end
      end
    end
  end

  // ------------------------------------------- sin/cos, lane 0 theta, 1 phi
  logic [8:0]      tv_q;
  tmeta_t          tm_q [9];
  trig_t           tr_q [8][2];
  trig_t           tr_d [8][2];
  sc_t             sc_q [2];
  sc_t             sc_d [2];
  logic [ANGLE_BITS-1:0] code [2];
  logic [RW-1:0]   roff [2];
  logic [RW-1:0]   rmir [2];
  logic [PW-1:0]   xprod [2];
  logic [59:0]     sq [2];
  logic [14:0]     s0 [2];
  logic [14:0]     c0 [2];
  logic [31:0]     rnd_s [2];
  logic [31:0]     rnd_c [2];
  logic signed [15:0] sv [2];
  logic signed [15:0] cv [2];

  assign code[0] = quo_q[QW][0][ANGLE_BITS-1:0];
  assign code[1] = quo_q[QW][1][ANGLE_BITS-1:0];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      // fold into [0, 1/8 turn], swapping sine and cosine above it
      roff[l]         = code[l][RW-1:0];
      tr_d[0][l]      = '0;
      tr_d[0][l].quad = code[l][ANGLE_BITS-1:ANGLE_BITS-2];
      tr_d[0][l].swap = roff[l] > EIGHTH;
      rmir[l]         = tr_d[0][l].swap ? RW'(QUARTER - {1'b0, roff[l]}) : roff[l];
      xprod[l]        = PW'(rmir[l]) * PW'(PI4_Q30) + (PW'(1) << (ANGLE_BITS - 4));
      tr_d[0][l].x    = 30'(xprod[l] >> (ANGLE_BITS - 3));

      tr_d[1][l]    = tr_q[0][l];
      sq[l]         = 60'(tr_q[0][l].x) * 60'(tr_q[0][l].x) + (60'(1) << 29);
      tr_d[1][l].x2 = 30'(sq[l] >> 30);

      tr_d[2][l]    = tr_q[1][l];
      tr_d[2][l].ps = rdiv(31'(tr_q[1][l].x2), RCP_42, SH_42);
      tr_d[2][l].pc = rdiv(31'(tr_q[1][l].x2), RCP_56, SH_56);

      tr_d[3][l]    = tr_q[2][l];
      tr_d[3][l].ps = mul30(31'(tr_q[2][l].x2), ONE_Q30 - tr_q[2][l].ps);
      tr_d[3][l].pc = mul30(31'(tr_q[2][l].x2), ONE_Q30 - tr_q[2][l].pc);

      tr_d[4][l]    = tr_q[3][l];
      tr_d[4][l].ps = rdiv(tr_q[3][l].ps, RCP_20, SH_20);
      tr_d[4][l].pc = rdiv(tr_q[3][l].pc, RCP_30, SH_30);

      tr_d[5][l]    = tr_q[4][l];
      tr_d[5][l].ps = mul30(31'(tr_q[4][l].x2), ONE_Q30 - tr_q[4][l].ps);
      tr_d[5][l].pc = mul30(31'(tr_q[4][l].x2), ONE_Q30 - tr_q[4][l].pc);

      tr_d[6][l]    = tr_q[5][l];
      tr_d[6][l].ps = rdiv(tr_q[5][l].ps, RCP_6, SH_6);
      tr_d[6][l].pc = rdiv(tr_q[5][l].pc, RCP_12, SH_12);

      tr_d[7][l]    = tr_q[6][l];
      tr_d[7][l].ps = mul30(31'(tr_q[6][l].x), ONE_Q30 - tr_q[6][l].ps);
      tr_d[7][l].pc = mul30(31'(tr_q[6][l].x2), ONE_Q30 - tr_q[6][l].pc);

      // Q30 -> Q14, last cosine term is 1 - x2*t/2
      rnd_s[l] = 32'(tr_q[7][l].ps) + 32'd32768;
      rnd_c[l] = 32'(ONE_Q30 - (tr_q[7][l].pc >> 1)) + 32'd32768;
      s0[l]    = 15'(rnd_s[l] >> 16);
      c0[l]    = 15'(rnd_c[l] >> 16);
      sv[l]    = tr_q[7][l].swap ? {1'b0, c0[l]} : {1'b0, s0[l]};
      cv[l]    = tr_q[7][l].swap ? {1'b0, s0[l]} : {1'b0, c0[l]};
      case (tr_q[7][l].quad)
        QUAD_I: begin
          sc_d[l].sn = sv[l];
          sc_d[l].cs = cv[l];
        end
        QUAD_II: begin
          sc_d[l].sn = cv[l];
          sc_d[l].cs = -sv[l];
        end
        QUAD_III: begin
          sc_d[l].sn = -sv[l];
          sc_d[l].cs = -cv[l];
        end
        default: begin
          sc_d[l].sn = -cv[l];
          sc_d[l].cs = sv[l];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      tv_q        <= {tv_q[7:0], dv_q[QW]};
      out_valid_q <= tv_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tm_q[0].base  <= dmeta_q[QW];
      tm_q[0].tex_u <= quo_q[QW][2][16:0];
      tm_q[0].tex_v <= quo_q[QW][3][16:0];
      for (int k = 1; k < 9; k++) begin
        tm_q[k] <= tm_q[k-1];
      end
      for (int k = 0; k < 8; k++) begin
        for (int l = 0; l < 2; l++) begin
          tr_q[k][l] <= tr_d[k][l];
        end
      end
      sc_q[0] <= sc_d[0];
      sc_q[1] <= sc_d[1];
    end
  end

  // ------------------------------------------ vector and output register
  out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.vertex_number <= tm_q[8].base.vertex_number;
      out_q.index_clamped <= tm_q[8].base.index_clamped;
      out_q.tex_u         <= tm_q[8].tex_u;
      out_q.tex_v         <= tm_q[8].tex_v;
      out_q.coord_x       <= mulq14(sc_q[1].cs, sc_q[0].sn, inward_q);
      out_q.coord_y       <= inward_q ? -sc_q[0].cs : sc_q[0].cs;
      out_q.coord_z       <= mulq14(sc_q[1].sn, sc_q[0].sn, inward_q);
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  // ------------------------------------------------------------ checks
  `UVS_ASSERT_NEXT(a_in_enters, in_if.valid && in_if.ready, dv_q[0])
  `UVS_ASSERT_NOW(a_rem_below_divisor, dv_q[QW], rem_q[QW][0] < dsr_q[QW])
  `UVS_ASSERT_NOW(a_coord_x_range, out_valid_q,
                  out_q.coord_x >= -16'sd16384 && out_q.coord_x <= 16'sd16384)
  `UVS_ASSERT_NOW(a_tex_bound, out_valid_q,
                  out_q.tex_u <= 17'd65536 && out_q.tex_v <= 17'd65536)

endmodule

`default_nettype wire

// ===== sim/uvs_vertex_checker.sv =====
`default_nettype none

module uvs_vertex_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  uvs_pkg::cfg_idx_e cfg_idx_i,
  input  logic [8:0]        cfg_wdata_i,
  uvs_stream_if             in_mon,
  uvs_stream_if             out_mon,
  output int                errors_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import uvs_pkg::*;

  localparam longint unsigned PI4 = 64'd843314857;
  localparam longint unsigned ONE = 64'd1 << 30;

  logic [8:0] step_q;
  logic       inward_q;
  out_word_t  vertex_q[$];
  int         errors;

  assign errors_o  = errors;
  assign pending_o = vertex_q.size();

  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // quadrant split, eighth-turn mirror, Taylor chains in Q30, result in Q14
  function automatic void sin_cos(input logic [15:0] code, output int sn, output int cs);
    logic [1:0]      quad;
    int unsigned     r;
    bit              mirror;
    longint unsigned x, x2, t;
    int              s0, c0, sv, cv;
    quad   = code[15:14];
    r      = code[13:0];
    mirror = r > 8192;
    if (mirror) r = 16384 - r;
    x  = (64'(r) * PI4 + 64'd4096) >> 13;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t  = ONE - x2 / 42;
    t  = ONE - fx_mul(x2, t) / 20;
    t  = ONE - fx_mul(x2, t) / 6;
    s0 = int'((fx_mul(x, t) + 64'd32768) >> 16);
    t  = ONE - x2 / 56;
    t  = ONE - fx_mul(x2, t) / 30;
    t  = ONE - fx_mul(x2, t) / 12;
    t  = ONE - fx_mul(x2, t) / 2;
    c0 = int'((t + 64'd32768) >> 16);
    sv = mirror ? c0 : s0;
    cv = mirror ? s0 : c0;
    case (quad)
      2'd0: begin sn = sv;  cs = cv;  end
      2'd1: begin sn = cv;  cs = -sv; end
      2'd2: begin sn = -sv; cs = -cv; end
      default: begin sn = -cv; cs = sv; end
    endcase
  endfunction

  // Q14 product, rounded half away from zero
  function automatic int q14_mul(int a, int b);
    int unsigned m;
    m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 8192) >> 14;
    return ((a < 0) != (b < 0)) ? -int'(m) : int'(m);
  endfunction

  function automatic out_word_t vertex_of(in_word_t w, logic [8:0] steps, logic inward);
    int unsigned     n, j, i;
    logic            clamp;
    longint unsigned th, ph;
    int              st, ct, sp, cp, vx, vy, vz;
    out_word_t       o;
    n = steps;
    if (n == 0) n = 1;
    if (n > 256) n = 256;
    j = w.lat_index;
    i = w.lon_index;
    clamp = 1'b0;
    if (j > n) begin j = n; clamp = 1'b1; end
    if (i > n) begin i = n; clamp = 1'b1; end
    th = (((64'(j) << 16) + n) / (2 * n)) & 64'hFFFF;
    ph = (((64'(i) << 17) + n) / (2 * n)) & 64'hFFFF;
    sin_cos(th[15:0], st, ct);
    sin_cos(ph[15:0], sp, cp);
    vx = q14_mul(cp, st);
    vy = ct;
    vz = q14_mul(sp, st);
    if (inward) begin
      vx = -vx; vy = -vy; vz = -vz;
    end
    o.vertex_number = 17'(j * (n + 1) + i);
    o.coord_x       = 16'(vx);
    o.coord_y       = 16'(vy);
    o.coord_z       = 16'(vz);
    o.tex_u         = 17'(((64'(i) << 16) + n / 2) / n);
    o.tex_v         = 17'(((64'(j) << 16) + n / 2) / n);
    o.index_clamped = clamp;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e, a;
    if (!rst_ni) begin
      step_q   <= 9'd16;
      inward_q <= 1'b0;
      errors   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_STEP_COUNT) step_q <= cfg_wdata_i;
        else inward_q <= cfg_wdata_i[0];
      end
      if (in_mon.valid && in_mon.ready)
        vertex_q.push_back(vertex_of(in_mon.data, step_q, inward_q));
      if (out_mon.valid && out_mon.ready) begin
        a = out_mon.data;
        if (vertex_q.size() == 0) begin
          $error("unexpected word: vertex_number %0d", a.vertex_number);
          errors++;
        end else begin
          e = vertex_q.pop_front();
          if (a.vertex_number !== e.vertex_number) begin
            $error("vertex_number exp %0d got %0d", e.vertex_number, a.vertex_number);
            errors++;
          end
          if (a.coord_x !== e.coord_x) begin
            $error("coord_x exp %0d got %0d", e.coord_x, a.coord_x);
            errors++;
          end
          if (a.coord_y !== e.coord_y) begin
            $error("coord_y exp %0d got %0d", e.coord_y, a.coord_y);
            errors++;
          end
          if (a.coord_z !== e.coord_z) begin
            $error("coord_z exp %0d got %0d", e.coord_z, a.coord_z);
            errors++;
          end
          if (a.tex_u !== e.tex_u) begin
            $error("tex_u exp %0d got %0d", e.tex_u, a.tex_u);
            errors++;
          end
          if (a.tex_v !== e.tex_v) begin
            $error("tex_v exp %0d got %0d", e.tex_v, a.tex_v);
            errors++;
          end
          if (a.index_clamped !== e.index_clamped) begin
            $error("index_clamped exp %0d got %0d", e.index_clamped, a.index_clamped);
            errors++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_uv_sphere_vertex_generator_core.sv =====
`default_nettype none

module tb_uv_sphere_vertex_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import uvs_pkg::*;

  localparam int LATENCY   = 28;      // QW + 11 pipeline stages
  localparam int CYC_LIMIT = 400000;  // far above the slowest clean run

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  cfg_idx_e  cfg_idx_i = CFG_STEP_COUNT;
  logic [8:0] cfg_wdata_i = '0;
  bit        no_idle = 1'b0;          // long stretch with no bubbles on either side
  int        errors, pending, cycles;
  logic [8:0] steps_now = 9'd16;      // tracks step_count for stimulus shaping

  uvs_stream_if #(.word_t(in_word_t))  in_if ();
  uvs_stream_if #(.word_t(out_word_t)) out_if ();

  uv_sphere_vertex_generator_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  uvs_vertex_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_mon(in_if), .out_mon(out_if),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("tb_uv_sphere_vertex_generator_core: errors");
      $finish;
    end
  end

  // sink side: back-pressure about 19% of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= no_idle || ($urandom_range(99) >= 19);
  end

  initial begin
    cycles       = 0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
  end

  // one register write; only issued with the pipe drained
  task automatic write_reg(cfg_idx_e idx, logic [8:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_STEP_COUNT) steps_now = val;
  endtask

  // stop offering words, then wait for every accepted word to come out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // push one grid point, holding valid until the word is taken
  task automatic send_point(logic [8:0] lat, logic [8:0] lon);
    bit took;
    if (!no_idle && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.data.lat_index <= lat;
    in_if.data.lon_index <= lon;
    do begin
      @(negedge clk_i);
      took = in_if.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // mostly in-range grid points, some out-of-range to hit the clamp
  task automatic random_point();
    int unsigned lim;
    lim = (steps_now == 0) ? 1 : (steps_now > 256 ? 256 : steps_now);
    if ($urandom_range(9) < 8)
      send_point(9'($urandom_range(lim)), 9'($urandom_range(lim)));
    else
      send_point(9'($urandom_range(511)), 9'($urandom_range(511)));
  endtask

  // step_count / inward settings per phase; includes zero and above-max counts
  logic [8:0] phase_steps[10] = '{9'd16, 9'd1, 9'd0, 9'd256, 9'd511,
                                  9'd300, 9'd3, 9'd7, 9'd100, 9'd255};
  bit         phase_inward[10] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                   1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset defaults (n=16, outward), poles, seam, quadrants, clamp
    send_point(9'd0,   9'd0);
    send_point(9'd16,  9'd16);
    send_point(9'd8,   9'd0);
    send_point(9'd8,   9'd4);
    send_point(9'd8,   9'd8);
    send_point(9'd8,   9'd12);
    send_point(9'd4,   9'd2);
    send_point(9'd12,  9'd14);
    send_point(9'd1,   9'd15);
    send_point(9'd17,  9'd0);
    send_point(9'd0,   9'd17);
    send_point(9'd511, 9'd511);
    send_point(9'd256, 9'd255);
    send_point(9'h155, 9'h0AA);
    send_point(9'h0AA, 9'h155);

    for (int p = 0; p < 10; p++) begin
      drain();
      write_reg(CFG_STEP_COUNT, phase_steps[p]);
      write_reg(CFG_INWARD_NORMALS, 9'(phase_inward[p]));
      no_idle = (p == 3);
      if (p == 3) begin
        // n=256 corners, inward
        send_point(9'd0,   9'd256);
        send_point(9'd256, 9'd0);
        send_point(9'd128, 9'd64);
        send_point(9'd257, 9'd257);
      end
      repeat (94) random_point();
    end
    no_idle = 1'b0;

    drain();
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_uv_sphere_vertex_generator_core: clean");
    end else begin
      $display("tb_uv_sphere_vertex_generator_core: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== uv_sphere_vertex_generator_core.f =====
+incdir+rtl
rtl/uvs_pkg.sv
rtl/uvs_stream_if.sv
rtl/uv_sphere_vertex_generator_core.sv
sim/uvs_vertex_checker.sv
sim/tb_uv_sphere_vertex_generator_core.sv
